### rtl/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg
// Types and constants shared by the Playfair digraph cipher block.
// ----------------------------------------------------------------------------
package plf_pkg;

   // key square geometry
   localparam int SIDE          = 5;
   localparam int LETTER_BITS   = 5;
   localparam int CELLS_PER_REG = 12;
   localparam int CELL_REG_BITS = CELLS_PER_REG * LETTER_BITS;
   localparam int POS_BITS      = 3;

   typedef logic [LETTER_BITS-1:0] letter_type;
   typedef logic [POS_BITS-1:0]    pos_type;
   typedef letter_type [SIDE-1:0]  row_type;
   typedef row_type [SIDE-1:0]     square_type;

   localparam pos_type LAST_POS = pos_type'(SIDE - 1);

   // letter codes, A is zero
   localparam letter_type LETTER_I = letter_type'(8);
   localparam letter_type LETTER_J = letter_type'(9);
   localparam letter_type LETTER_Q = letter_type'(16);
   localparam letter_type LETTER_X = letter_type'(23);
   localparam letter_type LETTER_Z = letter_type'(25);

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_CELLS_LOW  = 2'd0,
      CSR_CELLS_HIGH = 2'd1,
      CSR_CELL_LAST  = 2'd2
   } csr_index_type;

   // input word
   typedef struct packed {
      logic       mode;
      letter_type first_letter;
      letter_type second_letter;
      logic       pad_second;
   } req_type;

   // result word
   typedef struct packed {
      letter_type first_out;
      letter_type second_out;
      logic       not_found;
   } rsp_type;

endpackage

### rtl/plf_square.sv
// ----------------------------------------------------------------------------
// plf_square
// Key square configuration registers, presented as a 5x5 grid of letters.
// ----------------------------------------------------------------------------
module plf_square (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [1:0]                            csr_index,
   input  logic [plf_pkg::CELL_REG_BITS-1:0]     csr_wdata,
   output plf_pkg::square_type                   square_out
);

   logic [plf_pkg::CELL_REG_BITS-1:0] cells_low_ff;
   logic [plf_pkg::CELL_REG_BITS-1:0] cells_low_in;
   logic [plf_pkg::CELL_REG_BITS-1:0] cells_high_ff;
   logic [plf_pkg::CELL_REG_BITS-1:0] cells_high_in;
   plf_pkg::letter_type               cell_last_ff;
   plf_pkg::letter_type               cell_last_in;

   // register write decode, unknown indexes ignored
   always_comb begin
      cells_low_in  = cells_low_ff;
      cells_high_in = cells_high_ff;
      cell_last_in  = cell_last_ff;
      if (csr_write) begin
         case (csr_index)
            plf_pkg::CSR_CELLS_LOW:  cells_low_in  = csr_wdata;
            plf_pkg::CSR_CELLS_HIGH: cells_high_in = csr_wdata;
            plf_pkg::CSR_CELL_LAST:  cell_last_in  = csr_wdata[plf_pkg::LETTER_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_low_ff  <= '0;
         cells_high_ff <= '0;
         cell_last_ff  <= '0;
      end else begin
         cells_low_ff  <= cells_low_in;
         cells_high_ff <= cells_high_in;
         cell_last_ff  <= cell_last_in;
      end
   end

   // cell r*5+c sits at row r, column c
   for (genvar r = 0; r < plf_pkg::SIDE; r++) begin : g_row
      for (genvar c = 0; c < plf_pkg::SIDE; c++) begin : g_col
         localparam int Idx = r * plf_pkg::SIDE + c;
         if (Idx < plf_pkg::CELLS_PER_REG) begin : g_low
            assign square_out[r][c] =
               cells_low_ff[Idx*plf_pkg::LETTER_BITS +: plf_pkg::LETTER_BITS];
         end else if (Idx < 2 * plf_pkg::CELLS_PER_REG) begin : g_high
            assign square_out[r][c] = cells_high_ff[(Idx-plf_pkg::CELLS_PER_REG)*
               plf_pkg::LETTER_BITS +: plf_pkg::LETTER_BITS];
         end else begin : g_last
            assign square_out[r][c] = cell_last_ff;
         end
      end
   end

endmodule

### rtl/plf_xform.sv
// ----------------------------------------------------------------------------
// plf_xform
// Pair preparation, key square search and Playfair move for one letter pair.
// ----------------------------------------------------------------------------
module plf_xform (
   input  plf_pkg::square_type square_in,
   input  plf_pkg::req_type    req_in,
   output plf_pkg::rsp_type    rsp_out
);

   plf_pkg::letter_type a;
   plf_pkg::letter_type b;
   logic                found_a;
   logic                found_b;
   plf_pkg::pos_type    row_a;
   plf_pkg::pos_type    col_a;
   plf_pkg::pos_type    row_b;
   plf_pkg::pos_type    col_b;
   plf_pkg::pos_type    row_a_new;
   plf_pkg::pos_type    col_a_new;
   plf_pkg::pos_type    row_b_new;
   plf_pkg::pos_type    col_b_new;

   // one position on or back, wrapping round the square
   function automatic plf_pkg::pos_type move_pos(input plf_pkg::pos_type pos,
                                                 input logic back);
      plf_pkg::pos_type res;
      if (back) begin
         res = (pos == '0) ? plf_pkg::LAST_POS : pos - plf_pkg::pos_type'(1);
      end else begin
         res = (pos == plf_pkg::LAST_POS) ? '0 : pos + plf_pkg::pos_type'(1);
      end
      return res;
   endfunction

   // encrypt preparation: J to I, doubled letters and padding
   always_comb begin
      a = req_in.first_letter;
      b = req_in.second_letter;
      if (!req_in.mode) begin
         if (a == plf_pkg::LETTER_J) a = plf_pkg::LETTER_I;
         if (req_in.pad_second) begin
            b = plf_pkg::LETTER_Z;
         end else begin
            if (b == plf_pkg::LETTER_J) b = plf_pkg::LETTER_I;
            if (a == b) b = (a == plf_pkg::LETTER_X) ? plf_pkg::LETTER_Q
                                                     : plf_pkg::LETTER_X;
         end
      end
   end

   // search from the last cell down so the lowest matching cell wins
   always_comb begin
      found_a = 1'b0;
      found_b = 1'b0;
      row_a   = '0;
      col_a   = '0;
      row_b   = '0;
      col_b   = '0;
      for (int r = plf_pkg::SIDE - 1; r >= 0; r--) begin
         for (int c = plf_pkg::SIDE - 1; c >= 0; c--) begin
            if (square_in[r][c] == a) begin
               found_a = 1'b1;
               row_a   = plf_pkg::pos_type'(r);
               col_a   = plf_pkg::pos_type'(c);
            end
            if (square_in[r][c] == b) begin
               found_b = 1'b1;
               row_b   = plf_pkg::pos_type'(r);
               col_b   = plf_pkg::pos_type'(c);
            end
         end
      end
   end

   // same column, same row, or rectangle corner swap
   always_comb begin
      row_a_new = row_a;
      col_a_new = col_a;
      row_b_new = row_b;
      col_b_new = col_b;
      if (col_a == col_b) begin
         row_a_new = move_pos(row_a, req_in.mode);
         row_b_new = move_pos(row_b, req_in.mode);
      end else if (row_a == row_b) begin
         col_a_new = move_pos(col_a, req_in.mode);
         col_b_new = move_pos(col_b, req_in.mode);
      end else begin
         col_a_new = col_b;
         col_b_new = col_a;
      end
   end

   // result, zeroed when a letter is missing
   always_comb begin
      if (found_a && found_b) begin
         rsp_out.first_out  = square_in[row_a_new][col_a_new];
         rsp_out.second_out = square_in[row_b_new][col_b_new];
         rsp_out.not_found  = 1'b0;
      end else begin
         rsp_out.first_out  = '0;
         rsp_out.second_out = '0;
         rsp_out.not_found  = 1'b1;
      end
   end

endmodule

### rtl/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair encrypt/decrypt, one pair per cycle unless stalled, 5x5 key square.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+----------------------------------
//   req     | in        | req_valid/stall  | mode, letters, pad flag
//   rsp     | out       | rsp_valid/stall  | transformed letters, not_found
//   csr     | in        | csr_valid/ready  | register index, 60-bit data
//
// One pair is accepted every cycle while req_stall is low; each pair passes
// through the input register, then the search and move logic into the
// result register, and its result is taken from rsp when the output is not
// stalled.
// Reset clears the key square to all A and empties both stages.
// A stalled result holds the result register; the input register still
// takes one more pair if it is empty, after which req_stall rises.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  plf_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output plf_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [plf_pkg::CELL_REG_BITS-1:0] csr_wdata
);

   plf_pkg::square_type square;
   logic                in_valid_ff;
   logic                in_valid_in;
   plf_pkg::req_type    in_data_ff;
   plf_pkg::req_type    in_data_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   plf_pkg::rsp_type    out_data_ff;
   plf_pkg::rsp_type    out_data_in;
   plf_pkg::rsp_type    result;
   logic                out_advance;
   logic                in_advance;

   assign csr_ready = 1'b1;

   plf_square u_square (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .square_out (square)
   );

   plf_xform u_xform (
      .square_in (square),
      .req_in    (in_data_ff),
      .rsp_out   (result)
   );

   // stage enables
   assign out_advance = !out_valid_ff || !rsp_stall;
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_stall   = !in_advance;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (in_advance) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_advance) begin
         out_valid_in = in_valid_ff;
         out_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### rtl/plf_checker.sv
// ----------------------------------------------------------------------------
// plf_checker
// Port-level checks on the Playfair digraph cipher, bound to the top level.
// ----------------------------------------------------------------------------
module plf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input plf_pkg::rsp_type rsp_data
);

   // no result straight out of reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input back-pressure only while a result is held back
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with no held result");

   // a missing letter gives zero letters
   a_not_found_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.not_found) |->
         (rsp_data.first_out == '0 && rsp_data.second_out == '0))
      else $error("not_found result carries letters");

   // a held result keeps its word
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind playfair_digraph_cipher plf_checker u_plf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/sv/playfair_digraph_cipher_test.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_test
// Self-checking bench for the Playfair digraph cipher. Key squares are loaded
// over the csr port while the block is idle; letter pairs are pushed through
// with random gaps and output stalls, and every result word is compared with
// a local model of the square lookup and the row, column and rectangle moves.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_test;
   timeunit 1ns;
   timeprecision 1ps;

   import plf_pkg::*;

   localparam int         NUM_CELLS      = SIDE * SIDE;
   localparam logic       MODE_ENCRYPT   = 1'b0;
   localparam logic       MODE_DECRYPT   = 1'b1;
   localparam logic [1:0] CSR_SPARE      = 2'd3;
   localparam int         SETTLE_CYCLES  = 4;
   localparam int         DRAIN_CYCLES   = 8;
   localparam int         WATCHDOG_LIMIT = 500;
   localparam int         REPORT_LIMIT   = 20;

   // scoreboard: key square copy plus the queue of predicted result words
   class cipher_scoreboard;
      letter_type  cells[NUM_CELLS];
      rsp_type     pending_outputs[$];
      int unsigned fail_count;
      int unsigned missing_count;

      function new();
         foreach (cells[i]) cells[i] = '0;
         fail_count    = 0;
         missing_count = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [CELL_REG_BITS-1:0] data);
         case (index)
            CSR_CELLS_LOW: begin
               for (int i = 0; i < CELLS_PER_REG; i++) cells[i] = data[i*LETTER_BITS +: LETTER_BITS];
            end
            CSR_CELLS_HIGH: begin
               for (int i = 0; i < CELLS_PER_REG; i++)
                  cells[CELLS_PER_REG+i] = data[i*LETTER_BITS +: LETTER_BITS];
            end
            CSR_CELL_LAST: begin
               cells[NUM_CELLS-1] = data[LETTER_BITS-1:0];
            end
            default: ;
         endcase
      endfunction

      // lowest cell holding the letter, or -1
      function int find_cell(letter_type code);
         for (int i = 0; i < NUM_CELLS; i++) begin
            if (cells[i] == code) return i;
         end
         return -1;
      endfunction

      function rsp_type predict_pair(req_type pair);
         letter_type a;
         letter_type b;
         int         pa, pb, ra, ca, rb, cb, stp, swap;
         rsp_type    r;
         a = pair.first_letter;
         b = pair.second_letter;
         // encrypt side preparation: J folds to I, doubles split, pad gives Z
         if (pair.mode == MODE_ENCRYPT) begin
            if (a == LETTER_J) a = LETTER_I;
            if (pair.pad_second) begin
               b = LETTER_Z;
            end else begin
               if (b == LETTER_J) b = LETTER_I;
               if (a == b) b = (a == LETTER_X) ? LETTER_Q : LETTER_X;
            end
         end
         stp = (pair.mode == MODE_DECRYPT) ? SIDE - 1 : 1;
         pa  = find_cell(a);
         pb  = find_cell(b);
         r   = '0;
         if (pa < 0 || pb < 0) begin
            r.not_found = 1'b1;
            return r;
         end
         ca = pa % SIDE;
         ra = pa / SIDE;
         cb = pb % SIDE;
         rb = pb / SIDE;
         // same column, then same row, else rectangle corners
         if (ca == cb) begin
            ra = (ra + stp) % SIDE;
            rb = (rb + stp) % SIDE;
         end else if (ra == rb) begin
            ca = (ca + stp) % SIDE;
            cb = (cb + stp) % SIDE;
         end else begin
            swap = ca;
            ca   = cb;
            cb   = swap;
         end
         r.first_out  = cells[ra*SIDE + ca];
         r.second_out = cells[rb*SIDE + cb];
         return r;
      endfunction

      function int pending();
         return pending_outputs.size();
      endfunction

      function void note_pair(req_type pair);
         pending_outputs.push_back(predict_pair(pair));
      endfunction

      task report(string what);
         if (fail_count < REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
         fail_count++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_outputs.size() == 0) begin
            report($sformatf("result word %h with no pair outstanding", got));
         end else begin
            want = pending_outputs.pop_front();
            if (want.not_found) missing_count++;
            if (got.first_out != want.first_out)
               report($sformatf("first_out %0d, wanted %0d", got.first_out, want.first_out));
            if (got.second_out != want.second_out)
               report($sformatf("second_out %0d, wanted %0d", got.second_out, want.second_out));
            if (got.not_found != want.not_found)
               report($sformatf("not_found %0b, wanted %0b", got.not_found, want.not_found));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [1:0]               csr_index;
   logic [CELL_REG_BITS-1:0] csr_wdata;

   cipher_scoreboard sb;
   letter_type       key_cells[NUM_CELLS];
   bit               no_idling;
   bit               word_moved;
   int unsigned      pairs_taken;
   int unsigned      results_seen;
   int unsigned      squares_loaded;
   int unsigned      quiet_cycles;
   int unsigned      stall_mark;
   int unsigned      stall_left;

   playfair_digraph_cipher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int draw_idle();
      return no_idling ? 0 : $urandom_range(0, 3);
   endfunction

   // monitor and watchdog, sampled on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         word_moved = 1'b0;
         if (req_valid && !req_stall) begin
            sb.note_pair(req_data);
            pairs_taken++;
            word_moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
            results_seen++;
            word_moved = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            sb.write_register(csr_index, csr_wdata);
            word_moved = 1'b1;
         end
         quiet_cycles = word_moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no word moved for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver: a fresh stall length is drawn after every accepted result
   always @(negedge clock) begin
      if (results_seen != stall_mark) begin
         stall_mark = results_seen;
         stall_left = draw_idle();
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type pair_of(logic mode, byte a, byte b, logic pad);
      req_type w;
      w.mode          = mode;
      w.first_letter  = letter_type'(a - "A");
      w.second_letter = letter_type'(b - "A");
      w.pad_second    = pad;
      return w;
   endfunction

   // mostly letters that sit in the square, now and then any letter
   function automatic letter_type pick_letter();
      letter_type code;
      code = key_cells[$urandom_range(0, NUM_CELLS-1)];
      if ($urandom_range(0, 7) == 0 || code > LETTER_Z) code = letter_type'($urandom_range(0, 25));
      return code;
   endfunction

   function automatic req_type random_pair();
      req_type w;
      w.mode          = logic'($urandom_range(0, 1));
      w.first_letter  = pick_letter();
      w.second_letter = ($urandom_range(0, 9) == 0) ? w.first_letter : pick_letter();
      w.pad_second    = ($urandom_range(0, 5) == 0);
      return w;
   endfunction

   function automatic logic [CELL_REG_BITS-1:0] pack_cells(int base);
      logic [CELL_REG_BITS-1:0] v;
      for (int i = 0; i < CELLS_PER_REG; i++) v[i*LETTER_BITS +: LETTER_BITS] = key_cells[base+i];
      return v;
   endfunction

   // called at a falling edge; leaves valid high so back-to-back words flow
   task automatic send_pair(req_type w);
      int gap;
      gap = draw_idle();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [CELL_REG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write the whole square, plus a write to the unused index that must do nothing
   task automatic load_key_cells();
      logic [CELL_REG_BITS-1:0] last_word;
      last_word = CELL_REG_BITS'({$urandom, $urandom});
      last_word[LETTER_BITS-1:0] = key_cells[NUM_CELLS-1];
      csr_write(CSR_CELLS_LOW, pack_cells(0));
      csr_write(CSR_CELLS_HIGH, pack_cells(CELLS_PER_REG));
      csr_write(CSR_CELL_LAST, last_word);
      csr_write(CSR_SPARE, CELL_REG_BITS'({$urandom, $urandom}));
      csr_valid <= 1'b0;
      squares_loaded++;
   endtask

   task automatic key_from_text(string s);
      for (int i = 0; i < NUM_CELLS; i++) key_cells[i] = letter_type'(s[i] - "A");
   endtask

   task automatic shuffle_key();
      int order[26];
      int j, t;
      foreach (order[i]) order[i] = i;
      for (int i = 25; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < NUM_CELLS; i++) key_cells[i] = letter_type'(order[i]);
   endtask

   task automatic run_random(int count, bit pressure);
      for (int n = 0; n < count; n++) begin
         if (pressure && n == count / 2) drain_results();
         send_pair(random_pair());
      end
   endtask

   // stimulus
   initial begin
      req_type directed[$];
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      no_idling      = 1'b0;
      word_moved     = 1'b0;
      pairs_taken    = 0;
      results_seen   = 0;
      squares_loaded = 0;
      quiet_cycles   = 0;
      stall_mark     = 0;
      stall_left     = 0;
      foreach (key_cells[i]) key_cells[i] = '0;
      sb = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // square straight out of reset: every cell holds A
      send_pair(pair_of(MODE_DECRYPT, "A", "A", 1'b0));
      send_pair(pair_of(MODE_ENCRYPT, "A", "A", 1'b0));
      send_pair(pair_of(MODE_ENCRYPT, "Z", "B", 1'b1));
      send_pair(pair_of(MODE_DECRYPT, "A", "B", 1'b0));
      run_random(40, 1'b0);
      settle();

      // textbook square, directed corner cases
      key_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ");
      load_key_cells();
      directed = '{
         pair_of(MODE_ENCRYPT, "H", "I", 1'b0),   // rectangle
         pair_of(MODE_ENCRYPT, "E", "X", 1'b0),   // same row
         pair_of(MODE_ENCRYPT, "D", "E", 1'b0),   // same column
         pair_of(MODE_ENCRYPT, "P", "F", 1'b0),   // row wrap
         pair_of(MODE_ENCRYPT, "L", "L", 1'b0),   // doubled letter gets X
         pair_of(MODE_ENCRYPT, "X", "X", 1'b0),   // doubled X gets Q
         pair_of(MODE_ENCRYPT, "J", "A", 1'b0),   // J folds to I
         pair_of(MODE_ENCRYPT, "A", "J", 1'b0),
         pair_of(MODE_ENCRYPT, "J", "J", 1'b0),
         pair_of(MODE_ENCRYPT, "I", "J", 1'b0),
         pair_of(MODE_ENCRYPT, "Z", "K", 1'b1),   // pad gives ZZ, one cell
         pair_of(MODE_ENCRYPT, "A", "B", 1'b1),
         pair_of(MODE_DECRYPT, "B", "D", 1'b1),   // pad ignored on decrypt
         pair_of(MODE_DECRYPT, "J", "A", 1'b0),   // J not in square
         pair_of(MODE_DECRYPT, "P", "T", 1'b0),   // column wrap upwards
         pair_of(MODE_DECRYPT, "P", "F", 1'b0),   // row wrap leftwards
         pair_of(MODE_DECRYPT, "W", "Z", 1'b0),
         pair_of(MODE_ENCRYPT, "A", "Z", 1'b0),
         pair_of(MODE_ENCRYPT, "Z", "A", 1'b0),
         pair_of(MODE_DECRYPT, "A", "Z", 1'b0),
         pair_of(MODE_DECRYPT, "Z", "Z", 1'b0)
      };
      foreach (directed[i]) send_pair(directed[i]);
      no_idling = 1'b1;
      run_random(120, 1'b0);
      no_idling = 1'b0;
      run_random(130, 1'b0);
      settle();

      // random permutations, one letter left out each time
      for (int k = 0; k < 4; k++) begin
         shuffle_key();
         load_key_cells();
         no_idling = (k == 2);
         run_random(200, k == 1);
         settle();
      end
      no_idling = 1'b0;

      // repeated letters and codes above Z in the square
      foreach (key_cells[i]) key_cells[i] = letter_type'($urandom_range(0, 31));
      key_cells[NUM_CELLS-1] = letter_type'($urandom_range(0, 25));
      load_key_cells();
      run_random(200, 1'b0);
      settle();

      // all-ones cell registers
      foreach (key_cells[i]) key_cells[i] = '1;
      key_cells[NUM_CELLS-1] = LETTER_Z;
      load_key_cells();
      send_pair(pair_of(MODE_DECRYPT, "Z", "Z", 1'b0));
      send_pair(pair_of(MODE_ENCRYPT, "Z", "C", 1'b1));
      send_pair(pair_of(MODE_ENCRYPT, "A", "B", 1'b0));
      run_random(50, 1'b0);
      settle();

      // all-zero cell registers
      foreach (key_cells[i]) key_cells[i] = '0;
      load_key_cells();
      run_random(30, 1'b0);
      settle();

      // textbook square again, with a full drain half way
      key_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ");
      load_key_cells();
      run_random(300, 1'b1);

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d letter pairs and %0d result words over %0d key squares",
               pairs_taken, results_seen, squares_loaded);
      $display("%0d results flagged a missing letter, %0d mismatches",
               sb.missing_count, sb.fail_count);
      if (sb.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
